// File: rtl/core/bmhq_pkg.sv
`timescale 1ns / 1ps

package bmhq_pkg;

   // heap geometry
   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = IDX_W + 2;

   // word field widths
   localparam int KEY_W = 32;
   localparam int ENT_W = 9;

   // operation codes
   localparam logic FUNC_INSERT     = 1'b0;
   localparam logic FUNC_DELETE_MIN = 1'b1;

   // key reported for an empty heap
   localparam logic signed [KEY_W-1:0] EMPTY_KEY = -KEY_W'(1);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DEL_LAST = 8'b0000_0010,
      ST_DEL_KEY  = 8'b0000_0100,
      ST_UP_RD    = 8'b0000_1000,
      ST_UP_CMP   = 8'b0001_0000,
      ST_DN_RD    = 8'b0010_0000,
      ST_DN_CMP   = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

endpackage

// File: rtl/core/bmhq_ram.sv
`timescale 1ns / 1ps

module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write one entry, read two with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// File: rtl/core/binary_min_heap_queue.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_func, req_key
// rsp       out        rsp_valid/stall    rsp_ok, rsp_min_key, rsp_empty_res, rsp_entries
//
// One operation at a time; a refused one goes straight to the done state.
// Insert: the new key climbs while its parent is larger. Delete: the last entry sinks
// from the root toward the smaller child; a delete that empties the heap skips this.
// Each level is one read, then compare and write-back.
// Reset empties the heap at once; the key store is never cleared. A finished word waits in
// the output register while the next request is taken; a stall holds back the next.

module binary_min_heap_queue
   import bmhq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   input  logic signed [KEY_W-1:0] req_key,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_ok,
   output logic signed [KEY_W-1:0] rsp_min_key,
   output logic                    rsp_empty_res,
   output logic [ENT_W-1:0]        rsp_entries
);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [KEY_W-1:0] root_ff, root_in;
   logic                    ok_ff, ok_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic signed [KEY_W-1:0] rsp_min_ff, rsp_min_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic [ENT_W-1:0]        rsp_ent_ff, rsp_ent_in;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [KEY_W-1:0]        wr_data;
   logic [IDX_W-1:0]        rd_addr_a, rd_addr_b;
   logic [KEY_W-1:0]        rd_data_a, rd_data_b;

   logic [IDX_W-1:0]        parent;
   logic [CHILD_W-1:0]      left_idx, right_idx, cnt_ext;
   logic signed [KEY_W-1:0] left_key, right_key, pick_key;
   logic [IDX_W-1:0]        pick_idx;
   logic                    take_right;
   logic                    req_take;
   logic                    rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // child and parent positions of the hole
   assign parent    = (pos_ff - IDX_W'(1)) >> 1;
   assign left_idx  = {1'b0, pos_ff, 1'b1};
   assign right_idx = left_idx + CHILD_W'(1);
   assign cnt_ext   = CHILD_W'(cnt_ff);

   // pick the smaller child, left on a tie
   assign left_key   = $signed(rd_data_a);
   assign right_key  = $signed(rd_data_b);
   assign take_right = (right_idx < cnt_ext) && (left_key > right_key);
   assign pick_key   = take_right ? right_key : left_key;
   assign pick_idx   = take_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];

   assign rd_addr_a = (state_ff == ST_UP_RD)    ? parent :
                      (state_ff == ST_DEL_LAST) ? cnt_ff[IDX_W-1:0] :
                                                  left_idx[IDX_W-1:0];
   assign rd_addr_b = right_idx[IDX_W-1:0];

   bmhq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // sequence one operation, moving a hole through the heap
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      root_in      = root_ff;
      ok_in        = ok_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = key_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ent_in   = rsp_ent_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               key_in = req_key;
               if (req_func == FUNC_INSERT) begin
                  if (cnt_ff < CNT_W'(CAPACITY)) begin
                     ok_in    = 1'b1;
                     pos_in   = cnt_ff[IDX_W-1:0];
                     cnt_in   = cnt_ff + CNT_W'(1);
                     state_in = ST_UP_RD;
                  end else begin
                     ok_in    = 1'b0;
                     state_in = ST_DONE;
                  end
               end else begin
                  if (cnt_ff != '0) begin
                     ok_in    = 1'b1;
                     cnt_in   = cnt_ff - CNT_W'(1);
                     state_in = ST_DEL_LAST;
                  end else begin
                     ok_in    = 1'b0;
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DEL_LAST: begin
            state_in = ST_DEL_KEY;
         end
         ST_DEL_KEY: begin
            // last entry becomes the sinking key
            key_in = $signed(rd_data_a);
            pos_in = '0;
            state_in = (cnt_ff == '0) ? ST_DONE : ST_DN_RD;
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               root_in  = key_ff;
               state_in = ST_DONE;
            end else begin
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if ($signed(rd_data_a) > key_ff) begin
               wr_data  = rd_data_a;
               pos_in   = parent;
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DN_RD: begin
            if (left_idx >= cnt_ext) begin
               wr_en = 1'b1;
               if (pos_ff == '0) begin
                  root_in = key_ff;
               end
               state_in = ST_DONE;
            end else begin
               state_in = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (key_ff > pick_key) begin
               wr_data = pick_key;
               if (pos_ff == '0) begin
                  root_in = pick_key;
               end
               pos_in   = pick_idx;
               state_in = ST_DN_RD;
            end else begin
               if (pos_ff == '0) begin
                  root_in = key_ff;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand the word to the output register when it frees up
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_min_in   = (cnt_ff == '0) ? EMPTY_KEY : root_ff;
               rsp_empty_in = (cnt_ff == '0);
               rsp_ent_in   = ENT_W'(cnt_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      key_ff       <= key_in;
      root_ff      <= root_in;
      ok_ff        <= ok_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ent_ff   <= rsp_ent_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_min_key   = rsp_min_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_entries   = rsp_ent_ff;

endmodule

// File: tb/tb_binary_min_heap_queue.sv
`timescale 1ns / 1ps

module tb_binary_min_heap_queue;
   import bmhq_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PLAN_LEN    = 24;
   localparam int PEND_DEPTH  = 8;
   localparam int PEND_W      = $clog2(PEND_DEPTH);

   typedef struct packed {
      logic                    ok;
      logic signed [KEY_W-1:0] min_key;
      logic                    empty_res;
      logic [ENT_W-1:0]        entries;
   } heap_word_t;

   typedef struct packed {
      logic                    func;
      logic signed [KEY_W-1:0] key;
      logic                    pinned;
      heap_word_t              want;
   } plan_row_t;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic                    req_stall;
   logic                    req_func      = FUNC_INSERT;
   logic signed [KEY_W-1:0] req_key       = '0;
   logic                    rsp_valid;
   logic                    rsp_stall     = 1'b0;
   logic                    rsp_ok;
   logic signed [KEY_W-1:0] rsp_min_key;
   logic                    rsp_empty_res;
   logic [ENT_W-1:0]        rsp_entries;

   // typed expectation riding along with the request word
   logic       cur_pinned = 1'b0;
   heap_word_t cur_want   = '0;

   // shadow heap and the words it predicts
   logic signed [KEY_W-1:0] heap_keys [CAPACITY];
   int                      heap_size = 0;
   heap_word_t              pending_words [PEND_DEPTH];
   int                      pend_wr = 0;
   int                      pend_rd = 0;

   int  mismatches  = 0;
   int  cycle_count = 0;
   int  shadow_size = 0;
   int  n_insert    = 0;
   int  n_delete    = 0;
   int  n_rejected  = 0;
   int  peak_size   = 0;
   bit  quiet       = 1'b0;

   plan_row_t directed_plan [PLAN_LEN];

   binary_min_heap_queue u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ok        (rsp_ok),
      .rsp_min_key   (rsp_min_key),
      .rsp_empty_res (rsp_empty_res),
      .rsp_entries   (rsp_entries)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // apply one operation to the shadow heap and return the word it yields
   function automatic heap_word_t heap_apply(input logic func,
                                             input logic signed [KEY_W-1:0] key);
      heap_word_t              word;
      int                      pos;
      int                      up;
      int                      lc;
      int                      pick;
      logic signed [KEY_W-1:0] tmp;
      word.ok = 1'b0;
      if (func == FUNC_INSERT) begin
         if (heap_size < CAPACITY) begin
            heap_keys[heap_size] = key;
            pos = heap_size;
            heap_size++;
            // climb while the parent is strictly larger
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (heap_keys[up] <= heap_keys[pos]) break;
               tmp             = heap_keys[up];
               heap_keys[up]   = heap_keys[pos];
               heap_keys[pos]  = tmp;
               pos = up;
            end
            word.ok = 1'b1;
         end
      end else if (heap_size > 0) begin
         heap_size--;
         heap_keys[0] = heap_keys[heap_size];
         pos = 0;
         // sink toward the smaller child, left one on a tie
         while (2 * pos + 1 < heap_size) begin
            lc   = 2 * pos + 1;
            pick = lc;
            if (lc + 1 < heap_size && heap_keys[lc] > heap_keys[lc + 1]) pick = lc + 1;
            if (heap_keys[pos] <= heap_keys[pick]) break;
            tmp              = heap_keys[pos];
            heap_keys[pos]   = heap_keys[pick];
            heap_keys[pick]  = tmp;
            pos = pick;
         end
         word.ok = 1'b1;
      end
      word.empty_res = (heap_size == 0);
      word.min_key   = (heap_size == 0) ? EMPTY_KEY : heap_keys[0];
      word.entries   = ENT_W'(heap_size);
      return word;
   endfunction

   // narrow keys crowd a small range so ties show up often
   function automatic logic signed [KEY_W-1:0] pick_key(input bit narrow);
      int unsigned roll;
      roll = $urandom_range(9);
      if (narrow && roll < 8) roll = 2;
      case (roll)
         0:       return {1'b0, {(KEY_W-1){1'b1}}};
         1:       return {1'b1, {(KEY_W-1){1'b0}}};
         2, 3, 4: return $signed(KEY_W'($urandom_range(16))) - 8;
         default: return $signed(KEY_W'($urandom));
      endcase
   endfunction

   // present one word and hold it until taken
   task automatic send_word(input logic func, input logic signed [KEY_W-1:0] key,
                            input logic pinned, input heap_word_t want);
      while (!quiet && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= func;
      req_key    <= key;
      cur_pinned <= pinned;
      cur_want   <= want;
      do @(posedge clock); while (req_stall);
      // track the fill level for sequence planning
      if (func == FUNC_INSERT) begin
         if (shadow_size < CAPACITY) shadow_size++;
      end else if (shadow_size > 0) begin
         shadow_size--;
      end
   endtask

   task automatic send_op(input logic func, input bit narrow);
      send_word(func, pick_key(narrow), 1'b0, '0);
   endtask

   // stall the result side at random, except in quiet stretches
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 30);
   end

   // check returned words, then predict for accepted requests
   always @(posedge clock) begin
      heap_word_t want;
      heap_word_t pred;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pend_wr == pend_rd) begin
               $display("%0t: unexpected word ok=%0b min_key=%0d empty=%0b entries=%0d",
                        $time, rsp_ok, rsp_min_key, rsp_empty_res, rsp_entries);
               mismatches++;
            end else begin
               want = pending_words[pend_rd[PEND_W-1:0]];
               pend_rd++;
               if (rsp_ok !== want.ok) begin
                  $display("%0t: ok mismatch, expected %0b, got %0b",
                           $time, want.ok, rsp_ok);
                  mismatches++;
               end
               if (rsp_min_key !== want.min_key) begin
                  $display("%0t: min_key mismatch, expected %0d, got %0d",
                           $time, $signed(want.min_key), rsp_min_key);
                  mismatches++;
               end
               if (rsp_empty_res !== want.empty_res) begin
                  $display("%0t: empty_res mismatch, expected %0b, got %0b",
                           $time, want.empty_res, rsp_empty_res);
                  mismatches++;
               end
               if (rsp_entries !== want.entries) begin
                  $display("%0t: entries mismatch, expected %0d, got %0d",
                           $time, want.entries, rsp_entries);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pred = heap_apply(req_func, req_key);
            if (req_func == FUNC_INSERT) n_insert++;
            else n_delete++;
            if (!pred.ok) n_rejected++;
            if (heap_size > peak_size) peak_size = heap_size;
            pending_words[pend_wr[PEND_W-1:0]] = cur_pinned ? cur_want : pred;
            pend_wr++;
         end
      end
   end

   // give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d words outstanding",
                  $time, pend_wr - pend_rd);
         $display("** binary_min_heap_queue: FAILED **");
         $finish;
      end
   end

   initial begin
      int i;
      // empty, extremes and ordering are typed in; tie rows go to the shadow heap
      directed_plan = '{
         '{FUNC_DELETE_MIN, 32'sd0,           1'b1, '{1'b0, EMPTY_KEY,        1'b1, 9'd0}},
         '{FUNC_INSERT,     32'sh7FFF_FFFF,   1'b1, '{1'b1, 32'sh7FFF_FFFF,   1'b0, 9'd1}},
         '{FUNC_INSERT,     32'sh8000_0000,   1'b1, '{1'b1, 32'sh8000_0000,   1'b0, 9'd2}},
         '{FUNC_INSERT,     32'sd0,           1'b1, '{1'b1, 32'sh8000_0000,   1'b0, 9'd3}},
         '{FUNC_INSERT,     -32'sd1,          1'b1, '{1'b1, 32'sh8000_0000,   1'b0, 9'd4}},
         '{FUNC_DELETE_MIN, 32'sd0,           1'b1, '{1'b1, -32'sd1,          1'b0, 9'd3}},
         '{FUNC_DELETE_MIN, 32'sh1234_5678,   1'b1, '{1'b1, 32'sd0,           1'b0, 9'd2}},
         '{FUNC_DELETE_MIN, 32'sd0,           1'b1, '{1'b1, 32'sh7FFF_FFFF,   1'b0, 9'd1}},
         '{FUNC_DELETE_MIN, 32'sd0,           1'b1, '{1'b1, EMPTY_KEY,        1'b1, 9'd0}},
         '{FUNC_DELETE_MIN, -32'sd1,          1'b1, '{1'b0, EMPTY_KEY,        1'b1, 9'd0}},
         '{FUNC_INSERT,     32'sd5,           1'b0, '0},
         '{FUNC_INSERT,     32'sd5,           1'b0, '0},
         '{FUNC_INSERT,     32'sd5,           1'b0, '0},
         '{FUNC_INSERT,     32'sd3,           1'b0, '0},
         '{FUNC_INSERT,     32'sd5,           1'b0, '0},
         '{FUNC_INSERT,     32'sd3,           1'b0, '0},
         '{FUNC_DELETE_MIN, 32'sd0,           1'b0, '0},
         '{FUNC_DELETE_MIN, 32'sd0,           1'b0, '0},
         '{FUNC_INSERT,     32'sh5555_5555,   1'b0, '0},
         '{FUNC_INSERT,     32'shAAAA_AAAA,   1'b0, '0},
         '{FUNC_DELETE_MIN, 32'sd0,           1'b0, '0},
         '{FUNC_INSERT,     -32'sd7,          1'b0, '0},
         '{FUNC_DELETE_MIN, 32'sd0,           1'b0, '0},
         '{FUNC_DELETE_MIN, 32'sd0,           1'b0, '0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < PLAN_LEN; i++) begin
         send_word(directed_plan[i].func, directed_plan[i].key,
                   directed_plan[i].pinned, directed_plan[i].want);
      end

      // mixed traffic leaning toward inserts
      for (i = 0; i < 120; i++) begin
         send_op(($urandom_range(99) < 65) ? FUNC_INSERT : FUNC_DELETE_MIN, 1'b0);
      end

      // fill to capacity back to back, then push past it
      quiet = 1'b1;
      while (shadow_size < CAPACITY) send_op(FUNC_INSERT, 1'($urandom_range(1)));
      repeat (4) send_op(FUNC_INSERT, 1'b0);
      quiet = 1'b0;

      // drain to empty, then pop past it
      while (shadow_size > 0) send_op(FUNC_DELETE_MIN, 1'b0);
      repeat (3) send_op(FUNC_DELETE_MIN, 1'b0);

      // balanced traffic on a narrow key range
      for (i = 0; i < 120; i++) begin
         send_op(($urandom_range(1) == 0) ? FUNC_INSERT : FUNC_DELETE_MIN, 1'b1);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pend_wr != pend_rd) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Ran %0d inserts and %0d delete-min ops, %0d of them refused;",
               n_insert, n_delete, n_rejected);
      $display("heap went from empty to %0d entries and back, with %0d mismatches.",
               peak_size, mismatches);
      if (mismatches == 0 && pend_wr == pend_rd) begin
         $display("** binary_min_heap_queue: PASSED **");
      end else begin
         $display("** binary_min_heap_queue: FAILED **");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_ram.sv
rtl/core/binary_min_heap_queue.sv
tb/tb_binary_min_heap_queue.sv
